FILE: hdl/sector_cut_disc_ring_raster_top_macros.svh
// assertion macros shared by the checker
`ifndef SECTOR_CUT_DISC_RING_RASTER_TOP_MACROS_SVH
`define SECTOR_CUT_DISC_RING_RASTER_TOP_MACROS_SVH
// implication checked on every edge outside reset
`define SCR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication checked outside reset
`define SCR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: hdl/scdr_pkg.sv
package scdr_pkg;
  localparam int MAX_RADIUS_DEF = 15;
  localparam int MASK_W = 61;
  localparam logic [7:0] COLS_RST = 8'd60;
  localparam logic [7:0] ROWS_RST = 8'd22;

  typedef enum logic [0:0] {
    REG_COLS = 1'b0,
    REG_ROWS = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } scan_st_t;

  typedef struct packed {
    logic       kind;
    logic signed [7:0] cx;
    logic signed [7:0] cy;
    logic [3:0] r;
    logic [3:0] w;
    logic [4:0] steps;
  } req_t;

  // quadrant a,b and angle <= 15*steps test on vector (x,y), both nonzero overall
  function automatic logic angle_le(input logic signed [6:0] x, input logic signed [6:0] y,
                                    input logic [5:0] steps);
    logic signed [7:0] a;
    logic signed [7:0] b;
    logic [2:0] q;
    logic [5:0] base;
    logic [5:0] m;
    logic signed [15:0] aa3;
    logic signed [8:0] t;
    logic res;
    if (x > 0 && y >= 0) begin
      a = 8'(x); b = 8'(y); q = 3'd0;
    end else if (x <= 0 && y > 0) begin
      a = 8'(y); b = -8'(x); q = 3'd1;
    end else if (x < 0 && y <= 0) begin
      a = -8'(x); b = -8'(y); q = 3'd2;
    end else begin
      a = -8'(y); b = 8'(x); q = 3'd3;
    end
    base = 6'(q) * 6'd6;
    m = steps - base;
    aa3 = 16'(a) * 16'(a) * 16'sd3;
    res = 1'b0;
    if (steps < base) res = 1'b0;
    else if (steps >= base + 6'd6) res = 1'b1;
    else begin
      unique case (m)
        6'd0: res = (b == 0);
        6'd1: begin
          t = 9'(2 * 9'(a)) - 9'(b);
          res = (t >= 0) && (16'(t) * 16'(t) >= aa3);
        end
        6'd2: res = (16'sd3 * 16'(b) * 16'(b) <= 16'(a) * 16'(a));
        6'd3: res = (b <= a);
        6'd4: res = (16'(b) * 16'(b) <= aa3);
        default: begin
          t = 9'(b) - 9'(2 * 9'(a));
          res = (t <= 0) || (16'(t) * 16'(t) <= aa3);
        end
      endcase
    end
    return res;
  endfunction
endpackage

FILE: hdl/scdr_front.sv
module scdr_front #(
  parameter int MAX_RADIUS = scdr_pkg::MAX_RADIUS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  scdr_pkg::req_t     in_req,
  output logic               q_valid,
  input  logic               q_ready,
  output scdr_pkg::req_t     q_req
);
  import scdr_pkg::*;
  // two-entry queue; radius saturated on entry
  req_t buf_r [2];
  req_t buf_nxt_d;
  logic [1:0] cnt_r, cnt_nxt;
  logic wp_r, rp_r;
  logic push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_req    = buf_r[rp_r];
  assign push = in_valid && in_ready;
  assign pop  = q_valid && q_ready;

  always_comb begin
    buf_nxt_d = in_req;
    if (32'(in_req.r) > MAX_RADIUS) buf_nxt_d.r = 4'(MAX_RADIUS);
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= 1'b0; rp_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
    end
    if (push) buf_r[wp_r] <= buf_nxt_d;
  end
endmodule

FILE: hdl/scdr_back.sv
module scdr_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [7:0]                   cols,
  input  logic [7:0]                   rows,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  scdr_pkg::req_t               q_req,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [8:0]            out_row_index,
  output logic signed [8:0]            out_first_col,
  output logic [scdr_pkg::MASK_W-1:0]  out_pixel_mask,
  output logic                         out_row_visible,
  output logic                         out_last_row
);
  import scdr_pkg::*;
  scan_st_t st_r, st_nxt;
  req_t req_r;
  logic [4:0] ro_r;
  logic [5:0] co_r;
  logic [MASK_W-1:0] acc_r;
  logic ov_r;

  logic signed [6:0] c, vy, dy;
  logic signed [4:0] inner;
  logic [11:0] d, o4, i4;
  logic signed [9:0] row, col;
  logic vis, drawn, origin, row_end, pix_on;
  logic [4:0] r2;
  logic [5:0] span;

  assign span = {1'b0, req_r.r, 1'b0};
  assign r2 = {req_r.r, 1'b0};
  always_comb begin
    c = 7'(co_r) - 7'(span);
    dy = 7'(ro_r) - 7'(req_r.r);
    vy = 7'(dy <<< 1);
    d = 12'(14'(c) * 14'(c) + 14'(vy) * 14'(vy));
    o4 = 12'(req_r.r) * 12'(req_r.r) * 12'd4;
    inner = 5'(req_r.r) - 5'(req_r.w);
    i4 = 12'(10'(inner) * 10'(inner)) * 12'd4;
    origin = (c == 0) && (dy == 0);
    row = 10'(req_r.cy) + 10'(dy);
    col = 10'(req_r.cx) + 10'(c);
    vis = (row >= 0) && (row < $signed({2'b0, rows}));
    if (d > o4) drawn = 1'b0;
    else if (!req_r.kind) drawn = !(origin || angle_le(c, vy, {1'b0, req_r.steps}));
    else if (inner > 0 && d < i4) drawn = 1'b0;
    else if (origin) drawn = 1'b1;
    // ring cut only reaches past the first quadrant
    else drawn = !(!(c > 0 && vy >= 0) && angle_le(c, vy, 6'(req_r.steps) + 6'd6));
    pix_on = drawn && vis && col >= 0 && col < $signed({2'b0, cols});
    row_end = (co_r == {req_r.r, 2'b0});
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (q_valid) st_nxt = ST_SCAN;
      ST_SCAN: if (row_end && !(ov_r && !out_ready)) st_nxt = ST_EMIT;
      ST_EMIT: st_nxt = (ro_r == r2) ? ST_IDLE : ST_SCAN;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_ready = (st_r == ST_IDLE);
    out_valid = ov_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_valid && out_ready) ov_r <= 1'b0;
      if (st_r == ST_EMIT) ov_r <= 1'b1;
    end
    unique case (st_r)
      ST_IDLE: begin
        req_r <= q_req; ro_r <= '0; co_r <= '0; acc_r <= '0;
      end
      ST_SCAN: begin
        if (!(row_end && ov_r && !out_ready)) begin
          acc_r[co_r] <= pix_on;
          if (!row_end) co_r <= co_r + 6'd1;
        end
      end
      ST_EMIT: begin
        out_row_index <= 9'(row);
        out_first_col <= 9'(10'(req_r.cx) - 10'(span));
        out_pixel_mask <= acc_r;
        out_row_visible <= vis;
        out_last_row <= (ro_r == r2);
        ro_r <= ro_r + 5'd1; co_r <= '0; acc_r <= '0;
      end
      default: ;
    endcase
  end
endmodule

FILE: hdl/sector_cut_disc_ring_raster_top.sv
// channel | handshake              | payload
// in      | in_valid / in_ready    | figure, centre, radius, band, cut
// out     | out_valid / out_ready  | row, first column, mask, flags
// cfg     | psel/penable/pwrite    | canvas columns and rows
// the back scan unit tests one pixel per cycle while the output is not stalled,
// and takes a new request only when idle; a two-entry queue holds waiting requests.
// reset clears queue, scan state and sets canvas to 60 by 22.
// a stalled output holds the scan at the row's last pixel.
module sector_cut_disc_ring_raster_top #(
  parameter int MAX_RADIUS = scdr_pkg::MAX_RADIUS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_figure_kind,
  input  logic signed [7:0] in_centre_col,
  input  logic signed [7:0] in_centre_row,
  input  logic [3:0]  in_outer_radius,
  input  logic [3:0]  in_band_width,
  input  logic [4:0]  in_cut_steps,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [8:0] out_row_index,
  output logic signed [8:0] out_first_col,
  output logic [60:0] out_pixel_mask,
  output logic        out_row_visible,
  output logic        out_last_row,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import scdr_pkg::*;
  logic [7:0] cols_r, rows_r;
  req_t in_req, q_req;
  logic q_valid, q_ready;
  reg_idx_t widx;

  assign pready = 1'b1;
  assign widx = reg_idx_t'(paddr[2]);
  assign prdata = (paddr[1:0] != 2'b0) ? 32'd0 :
                  (widx == REG_COLS) ? {24'd0, cols_r} : {24'd0, rows_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLS_RST; rows_r <= ROWS_RST;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b0) begin
      if (widx == REG_COLS) cols_r <= pwdata[7:0];
      else rows_r <= pwdata[7:0];
    end
  end

  assign in_req = '{kind: in_figure_kind, cx: in_centre_col, cy: in_centre_row,
                    r: in_outer_radius, w: in_band_width, steps: in_cut_steps};

  scdr_front #(.MAX_RADIUS(MAX_RADIUS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_req,
    .q_valid, .q_ready, .q_req
  );

  scdr_back u_back (
    .clk, .rst_n, .cols(cols_r), .rows(rows_r), .q_valid, .q_ready, .q_req,
    .out_valid, .out_ready, .out_row_index, .out_first_col, .out_pixel_mask,
    .out_row_visible, .out_last_row
  );
endmodule

FILE: hdl/scdr_checker.sv
module scdr_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last_row,
  input logic pready
);
  `include "sector_cut_disc_ring_raster_top_macros.svh"
  `SCR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `SCR_ASSERT_NXT(a_last_hold, out_valid && !out_ready, $stable(out_last_row), "last flag moved")
  `SCR_ASSERT_IMP(a_pready, 1'b1, pready, "pready low")
endmodule

bind sector_cut_disc_ring_raster_top scdr_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_last_row, .pready
);
